// ===== rtl/hcb_pkg.sv =====
// Shared constants, types and controller states for the Huffman code builder.
`default_nettype none
package hcb_pkg;
    localparam int MAX_SYMBOLS   = 32;
    localparam int MAX_CODE_BITS = 31;
    localparam int NODE_DEPTH    = 2 * MAX_SYMBOLS - 1;
    localparam int IDX_W         = $clog2(NODE_DEPTH);
    localparam int CNT_W         = $clog2(MAX_SYMBOLS + 1);
    localparam int SYM_AW        = $clog2(MAX_SYMBOLS);
    localparam int SYM_W         = 8;
    localparam int COUNT_W       = 16;
    localparam int WEIGHT_W      = COUNT_W + $clog2(MAX_SYMBOLS);
    localparam int CODE_W        = 31;
    localparam int LEN_W         = 5;
    localparam int CREC_W        = LEN_W + CODE_W;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [SYM_W-1:0]    sym;
        logic [IDX_W-1:0]    idx;
    } t_entry;

    typedef enum logic [3:0] {
        ST_LOAD, ST_MERGE, ST_INSERT, ST_ROOT, ST_TRD, ST_TW0, ST_TW1,
        ST_ERD, ST_ECAP, ST_EOUT
    } t_state;

    typedef struct packed {
        logic load;
        logic load_last;
        logic merge;
        logic insert;
        logic root;
        logic trd;
        logic tw0;
        logic tw1;
        logic erd;
        logic ecap;
        logic eout_next;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic len_gt1;
        logic trav_done;
        logic k_last;
        logic out_valid;
    } t_sts;
endpackage
`default_nettype wire

// ===== rtl/hcb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/hcb_ctrl.sv =====
// Controller state machine: load, tree build, code walk and emission.
`default_nettype none
module hcb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_last,
    input  wire logic          i_out_ready,
    input  wire hcb_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output hcb_pkg::t_cmd      o_cmd
);
    hcb_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcb_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            hcb_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    o_cmd.load_last = 1'b1;
                    n_state = hcb_pkg::ST_MERGE;
                end
            end
            hcb_pkg::ST_MERGE: begin
                if (i_sts.len_gt1) begin
                    o_cmd.merge = 1'b1;
                    n_state = hcb_pkg::ST_INSERT;
                end else begin
                    n_state = hcb_pkg::ST_ROOT;
                end
            end
            hcb_pkg::ST_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state = hcb_pkg::ST_MERGE;
            end
            hcb_pkg::ST_ROOT: begin
                o_cmd.root = 1'b1;
                n_state = hcb_pkg::ST_TRD;
            end
            hcb_pkg::ST_TRD: begin
                if (i_sts.trav_done) begin
                    n_state = hcb_pkg::ST_ERD;
                end else begin
                    o_cmd.trd = 1'b1;
                    n_state = hcb_pkg::ST_TW0;
                end
            end
            hcb_pkg::ST_TW0: begin
                o_cmd.tw0 = 1'b1;
                n_state = hcb_pkg::ST_TW1;
            end
            hcb_pkg::ST_TW1: begin
                o_cmd.tw1 = 1'b1;
                n_state = hcb_pkg::ST_TRD;
            end
            hcb_pkg::ST_ERD: begin
                o_cmd.erd = 1'b1;
                n_state = hcb_pkg::ST_ECAP;
            end
            hcb_pkg::ST_ECAP: begin
                o_cmd.ecap = 1'b1;
                n_state = hcb_pkg::ST_EOUT;
            end
            hcb_pkg::ST_EOUT: begin
                if (i_out_ready) begin
                    if (i_sts.k_last) begin
                        o_cmd.finish = 1'b1;
                        n_state = hcb_pkg::ST_LOAD;
                    end else begin
                        o_cmd.eout_next = 1'b1;
                        n_state = hcb_pkg::ST_ERD;
                    end
                end
            end
            default: n_state = hcb_pkg::ST_LOAD;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_only_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == hcb_pkg::ST_LOAD)
        else $error("input ready outside load");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hcb_pkg::ST_EOUT) |-> i_sts.out_valid)
        else $error("emission state without valid result");
    a_merge_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.merge |-> i_sts.len_gt1)
        else $error("merge with fewer than two entries");
`endif
endmodule
`default_nettype wire

// ===== rtl/hcb_dp.sv =====
// Datapath: sorted entry list, node and code memories, output register.
`default_nettype none
module hcb_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire hcb_pkg::t_cmd                i_cmd,
    input  wire logic [hcb_pkg::SYM_W-1:0]    i_symbol,
    input  wire logic [hcb_pkg::COUNT_W-1:0]  i_count,
    input  wire logic                         i_out_ready,
    output hcb_pkg::t_sts                     o_sts,
    output logic                              o_out_valid,
    output logic [hcb_pkg::SYM_W-1:0]         o_out_symbol,
    output logic [hcb_pkg::CODE_W-1:0]        o_code_bits,
    output logic [hcb_pkg::LEN_W-1:0]         o_code_length,
    output logic                              o_final_res
);
    localparam int NS = hcb_pkg::MAX_SYMBOLS;

    hcb_pkg::t_entry                  r_list [NS];
    hcb_pkg::t_entry                  n_list [NS];
    logic [hcb_pkg::CNT_W-1:0]        r_len, r_n, r_k;
    logic [hcb_pkg::IDX_W-1:0]        r_next, r_p;
    logic [hcb_pkg::WEIGHT_W-1:0]     r_w;
    logic                             r_out_valid;

    logic                             full;
    logic [hcb_pkg::CNT_W-1:0]        len_new;
    hcb_pkg::t_entry                  src [NS];
    hcb_pkg::t_entry                  key;
    logic [hcb_pkg::CNT_W-1:0]        src_len;
    logic [NS-1:0]                    keep;

    logic [2*hcb_pkg::IDX_W-1:0]      child_rd;
    logic [hcb_pkg::CREC_W-1:0]       crec_rd, crec_wd, crec_child;
    logic [hcb_pkg::SYM_W-1:0]        sym_rd;
    logic                             crec_we, crec_re;
    logic [hcb_pkg::IDX_W-1:0]        crec_waddr, crec_raddr, p_m1;
    logic [hcb_pkg::CODE_W-1:0]       pcode;
    logic [hcb_pkg::LEN_W-1:0]        plen;

    assign full    = r_len == hcb_pkg::CNT_W'(NS);
    assign len_new = full ? r_len : r_len + 1'b1;
    assign p_m1    = r_p - 1'b1;

    // Insertion into the sorted list: entries that stay ahead of the key keep
    // their place, the first other slot takes the key, the rest move up one.
    always_comb begin
        if (i_cmd.insert) begin
            for (int i = 0; i < NS; i++) begin
                src[i] = (i + 2 < NS) ? r_list[(i + 2) % NS] : r_list[i];
            end
            key     = '{weight: r_w, sym: '0, idx: r_next};
            src_len = r_len - 2'd2;
        end else begin
            for (int i = 0; i < NS; i++) begin
                src[i] = r_list[i];
            end
            key     = '{weight: hcb_pkg::WEIGHT_W'(i_count), sym: i_symbol,
                        idx: hcb_pkg::IDX_W'(r_len)};
            src_len = r_len;
        end
        for (int i = 0; i < NS; i++) begin
            keep[i] = (hcb_pkg::CNT_W'(i) < src_len) &&
                      ((src[i].weight < key.weight) ||
                       ((src[i].weight == key.weight) &&
                        (i_cmd.insert || src[i].sym <= key.sym)));
        end
        for (int i = 0; i < NS; i++) begin
            if (keep[i]) begin
                n_list[i] = src[i];
            end else if (i == 0) begin
                n_list[i] = key;
            end else if (keep[(i + NS - 1) % NS]) begin
                n_list[i] = key;
            end else begin
                n_list[i] = src[(i + NS - 1) % NS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.load && !full) || i_cmd.insert) begin
            r_list <= n_list;
        end
        if (i_cmd.merge) begin
            r_w <= r_list[0].weight + r_list[1].weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_next      <= '0;
            r_p         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_len <= len_new;
            end
            if (i_cmd.load_last) begin
                r_n    <= len_new;
                r_next <= hcb_pkg::IDX_W'(len_new);
            end
            if (i_cmd.insert) begin
                r_len  <= r_len - 1'b1;
                r_next <= r_next + 1'b1;
            end
            if (i_cmd.root) begin
                r_p <= r_next;
                r_k <= '0;
            end
            if (i_cmd.tw1) begin
                r_p <= p_m1;
            end
            if (i_cmd.ecap) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.eout_next) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.finish) begin
                r_len <= '0;
            end
        end
    end

    // Child code: append the branch bit unless the parent is at full depth.
    assign pcode = crec_rd[hcb_pkg::CODE_W-1:0];
    assign plen  = crec_rd[hcb_pkg::CREC_W-1:hcb_pkg::CODE_W];
    always_comb begin
        if (plen < hcb_pkg::LEN_W'(hcb_pkg::MAX_CODE_BITS)) begin
            crec_child = {plen + 1'b1, pcode[hcb_pkg::CODE_W-2:0], i_cmd.tw1};
        end else begin
            crec_child = crec_rd;
        end
    end

    always_comb begin
        crec_we    = i_cmd.root || i_cmd.tw0 || i_cmd.tw1;
        crec_wd    = i_cmd.root ? '0 : crec_child;
        crec_waddr = i_cmd.root ? r_list[0].idx :
                     i_cmd.tw0  ? child_rd[2*hcb_pkg::IDX_W-1:hcb_pkg::IDX_W] :
                                  child_rd[hcb_pkg::IDX_W-1:0];
        crec_re    = i_cmd.trd || i_cmd.erd;
        crec_raddr = i_cmd.trd ? p_m1 : hcb_pkg::IDX_W'(r_k);
    end

    hcb_ram #(.WIDTH(2 * hcb_pkg::IDX_W), .DEPTH(hcb_pkg::NODE_DEPTH)) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.merge),
        .i_waddr (r_next),
        .i_wdata ({r_list[0].idx, r_list[1].idx}),
        .i_re    (i_cmd.trd),
        .i_raddr (p_m1),
        .o_rdata (child_rd)
    );

    hcb_ram #(.WIDTH(hcb_pkg::CREC_W), .DEPTH(hcb_pkg::NODE_DEPTH)) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (crec_we),
        .i_waddr (crec_waddr),
        .i_wdata (crec_wd),
        .i_re    (crec_re),
        .i_raddr (crec_raddr),
        .o_rdata (crec_rd)
    );

    hcb_ram #(.WIDTH(hcb_pkg::SYM_W), .DEPTH(NS)) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && !full),
        .i_waddr (r_len[hcb_pkg::SYM_AW-1:0]),
        .i_wdata (i_symbol),
        .i_re    (i_cmd.erd),
        .i_raddr (r_k[hcb_pkg::SYM_AW-1:0]),
        .o_rdata (sym_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.ecap) begin
            o_out_symbol  <= sym_rd;
            o_code_bits   <= pcode;
            o_code_length <= plen;
            o_final_res   <= (r_k + 1'b1) == r_n;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sts.len_gt1   = r_len > hcb_pkg::CNT_W'(1);
    assign o_sts.trav_done = r_p == hcb_pkg::IDX_W'(r_n);
    assign o_sts.k_last    = (r_k + 1'b1) == r_n;
    assign o_sts.out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= hcb_pkg::CNT_W'(NS))
        else $error("list length beyond capacity");
    a_cap_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ecap |=> r_out_valid)
        else $error("captured result not presented");
    a_insert_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |=> r_len == $past(r_len) - 1'b1)
        else $error("merge did not shorten list");
`endif
endmodule
`default_nettype wire

// ===== rtl/huffman_code_builder.sv =====
// Top level of the Huffman code builder: controller plus datapath.
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries symbol, count and last.
//   One item is accepted per cycle while loading; up to 32 leaves are kept,
//   sorted on arrival. Items beyond 32 are dropped, but a last flag on a
//   dropped item still starts the build.
//   After the last transfer the tree is built: n-1 merges, each a merge
//   step and an insert step. The codes are then assigned top-down: per
//   internal node, one read of the child and code memories, then one write per child.
//   Results (o_out_valid / i_out_ready) are emitted one per loaded symbol in
//   load order, each read only after the previous one is taken; final_res marks the last one.
//   A receiver stall holds the current result; nothing is lost.
//   Input is not taken again until the last result has been transferred.
//   Synchronous active-low reset returns to an empty load with no result
//   pending; memories need no clearing.
`default_nettype none
module huffman_code_builder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [hcb_pkg::SYM_W-1:0]   i_symbol,
    input  wire logic [hcb_pkg::COUNT_W-1:0] i_count,
    input  wire logic                        i_last,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [hcb_pkg::SYM_W-1:0]        o_out_symbol,
    output logic [hcb_pkg::CODE_W-1:0]       o_code_bits,
    output logic [hcb_pkg::LEN_W-1:0]        o_code_length,
    output logic                             o_final_res
);
    hcb_pkg::t_cmd cmd;
    hcb_pkg::t_sts sts;

    hcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_last),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    hcb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_symbol      (i_symbol),
        .i_count       (i_count),
        .i_out_ready   (i_out_ready),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_out_symbol  (o_out_symbol),
        .o_code_bits   (o_code_bits),
        .o_code_length (o_code_length),
        .o_final_res   (o_final_res)
    );
endmodule
`default_nettype wire

// ===== verif/tb_huffman_code_builder.sv =====
// Testbench for huffman_code_builder: directed and random symbol runs checked against a code predictor.
`timescale 1ns / 100ps

class hcb_scoreboard;
    typedef struct {
        logic [hcb_pkg::SYM_W-1:0]  sym;
        logic [hcb_pkg::CODE_W-1:0] code;
        logic [hcb_pkg::LEN_W-1:0]  len;
        logic                       fin;
    } t_code_rec;

    int unsigned tree_wt[hcb_pkg::NODE_DEPTH];
    int unsigned tree_sym[hcb_pkg::NODE_DEPTH];
    int unsigned tree_c0[hcb_pkg::NODE_DEPTH];
    int unsigned tree_c1[hcb_pkg::NODE_DEPTH];
    int unsigned order_q[hcb_pkg::MAX_SYMBOLS + 1];
    int unsigned leaves;
    t_code_rec   code_q[$];
    int          errors;

    function int pending();
        return code_q.size();
    endfunction

    function bit sorts_after(int unsigned a, int unsigned b);
        if (tree_wt[a] != tree_wt[b]) return tree_wt[a] > tree_wt[b];
        return tree_sym[a] > tree_sym[b];
    endfunction

    // Stores a leaf and, on last, builds the tree and queues one code per leaf.
    function void note_input(int unsigned sym, int unsigned cnt, bit last);
        int unsigned pos, len, nxt, a, b, w, p, k, n;
        longint unsigned code[hcb_pkg::NODE_DEPTH];
        int unsigned clen[hcb_pkg::NODE_DEPTH];
        t_code_rec r;
        if (leaves < hcb_pkg::MAX_SYMBOLS) begin
            pos = leaves;
            tree_wt[leaves] = cnt;
            tree_sym[leaves] = sym;
            while (pos > 0 && sorts_after(order_q[pos-1], leaves)) begin
                order_q[pos] = order_q[pos-1];
                pos--;
            end
            order_q[pos] = leaves;
            leaves++;
        end
        if (!last) return;
        n = leaves;
        len = n;
        nxt = n;
        while (len > 1 && nxt < hcb_pkg::NODE_DEPTH) begin
            a = order_q[0];
            b = order_q[1];
            w = tree_wt[a] + tree_wt[b];
            tree_wt[nxt] = w;
            tree_sym[nxt] = 0;
            tree_c0[nxt] = a;
            tree_c1[nxt] = b;
            for (int i = 0; i + 2 < len; i++) order_q[i] = order_q[i+2];
            len -= 2;
            pos = 0;
            while (pos < len && tree_wt[order_q[pos]] <= w) pos++;
            for (int i = len; i > pos; i--) order_q[i] = order_q[i-1];
            order_q[pos] = nxt;
            len++;
            nxt++;
        end
        foreach (code[i]) begin
            code[i] = 0;
            clen[i] = 0;
        end
        // parents always sit above their children, so walk downward
        for (int i = nxt; i > n; i--) begin
            p = i - 1;
            if (clen[p] < hcb_pkg::MAX_CODE_BITS) begin
                code[tree_c0[p]] = code[p] << 1;
                code[tree_c1[p]] = (code[p] << 1) | 1;
                clen[tree_c0[p]] = clen[p] + 1;
                clen[tree_c1[p]] = clen[p] + 1;
            end else begin
                code[tree_c0[p]] = code[p];
                code[tree_c1[p]] = code[p];
                clen[tree_c0[p]] = clen[p];
                clen[tree_c1[p]] = clen[p];
            end
        end
        for (k = 0; k < n; k++) begin
            r.sym = tree_sym[k][7:0];
            r.code = code[k][30:0];
            r.len = clen[k][4:0];
            r.fin = (k + 1 == n);
            code_q.push_back(r);
        end
        leaves = 0;
    endfunction

    function void check_result(logic [7:0] sym, logic [30:0] code, logic [4:0] len,
                               logic fin);
        t_code_rec e;
        if (code_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result sym=%0d code=%h len=%0d", sym, code, len);
            return;
        end
        e = code_q.pop_front();
        if (e.sym !== sym || e.code !== code || e.len !== len || e.fin !== fin) begin
            errors++;
            if (errors <= 10)
                $display("mismatch exp sym=%0d code=%h len=%0d fin=%0d / got sym=%0d code=%h len=%0d fin=%0d",
                         e.sym, e.code, e.len, e.fin, sym, code, len, fin);
        end
    endfunction
endclass

module tb_huffman_code_builder;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_symbol = '0;
    logic [15:0] i_count = '0;
    logic        i_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_symbol;
    logic [30:0] o_code_bits;
    logic [4:0]  o_code_length;
    logic        o_final_res;

    hcb_scoreboard sb = new();
    int sent_items;
    int hold_left;
    bit quiet;

    huffman_code_builder i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // one item per call; valid stays high into the next call unless idling
    task automatic send_item(int unsigned sym, int unsigned cnt, bit last);
        i_in_valid <= 1'b1;
        i_symbol <= sym[7:0];
        i_count <= cnt[15:0];
        i_last <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(sym, cnt, last);
        sent_items++;
        if (!quiet && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
    endtask

    task automatic send_run(int kind);
        int n;
        int unsigned cnt;
        case (kind)
            0: n = $urandom_range(33, 36);
            1: n = 32;
            2: n = $urandom_range(9, 32);
            default: n = $urandom_range(1, 8);
        endcase
        for (int i = 0; i < n; i++) begin
            if (kind == 1)
                cnt = (i < 8) ? 0 : (1 << ((i - 8) > 15 ? 15 : (i - 8)));
            else if ($urandom_range(0, 3) == 0)
                cnt = $urandom_range(0, 3);
            else
                cnt = $urandom_range(0, 65535);
            send_item($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(0, 255),
                      cnt, i == n - 1);
        end
    endtask

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready)
            sb.check_result(o_out_symbol, o_code_bits, o_code_length, o_final_res);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet || ($urandom_range(0, 99) >= 15);
        end
    end

    initial begin
        bit held = 0, paused = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: single symbol, field extremes, ties, duplicates, zero counts
        send_item(0, 1, 1);
        send_item(255, 65535, 1);
        send_item(255, 65535, 0);
        send_item(0, 0, 1);
        send_item(7, 5, 0);
        send_item(7, 5, 0);
        send_item(3, 5, 1);
        send_item(1, 0, 0);
        send_item(2, 0, 0);
        send_item(0, 0, 0);
        send_item(9, 65535, 1);
        send_item(170, 43690, 0);
        send_item(85, 21845, 0);
        send_item(128, 32768, 0);
        send_item(127, 32767, 1);
        while (sent_items < 440) begin
            if (!held && sent_items > 150) begin
                held = 1;
                hold_left = 400;
            end
            if (!paused && sent_items > 320) begin
                paused = 1;
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) @(posedge i_clk);
            end
            quiet = (sent_items > 220 && sent_items < 300);
            send_run($urandom_range(0, 19));
        end
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end
endmodule
